// ===== rtl/i2cmbe_pkg.sv =====
`default_nettype none
package i2cmbe_pkg;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_WAITACK = 3'd4;
  localparam logic [2:0] CMD_SENDACK = 3'd5;
  localparam logic [2:0] CMD_IDLE    = 3'd7;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd6;
  localparam int unsigned BYTE_BITS = 8;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_value;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_word_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  function automatic lines_t enter_phase(input logic [2:0] cmd, input logic [2:0] ph,
                                         input logic [7:0] sr, input lines_t cur);
    lines_t l;
    l = cur;
    unique case (cmd)
      CMD_START: begin
        l.scl = 1'b1;
        l.sda = (ph == 3'd0);
      end
      CMD_STOP: begin
        l.scl = 1'b1;
        l.sda = (ph != 3'd0);
      end
      CMD_WRITE: begin
        if (ph == 3'd0) begin
          l.scl = 1'b0;
        end else if (ph == 3'd1) begin
          l.scl = 1'b0;
          l.sda = sr[7];
        end else begin
          l.scl = 1'b1;
        end
      end
      CMD_READ, CMD_WAITACK: begin
        if (ph == 3'd0) begin
          l.scl = 1'b1;
          l.sda = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      CMD_SENDACK: begin
        if (ph == 3'd0) begin
          l.scl = 1'b0;
          l.sda = sr[0];
        end else if (ph == 3'd1) begin
          l.scl = 1'b1;
        end else begin
          l.scl = 1'b0;
          l.sda = 1'b1;
        end
      end
      default: begin
        l = cur;
      end
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cmbe_seq.sv =====
`default_nettype none
module i2cmbe_seq (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    step_en,
  input  i2cmbe_pkg::in_word_t   in_word,
  input  wire [7:0]              phase_ticks,
  output i2cmbe_pkg::out_word_t  out_word
);
  import i2cmbe_pkg::*;

  logic [2:0] cmd_r, cmd_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] hc_r, hc_nxt;
  logic [7:0] sr_r, sr_nxt;
  lines_t     lines_r, lines_nxt;
  logic       ack_r, ack_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [7:0] ticks;
  logic       done;
  lines_t     drive;

  assign ticks = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

  always_comb begin
    cmd_nxt   = cmd_r;
    ph_nxt    = ph_r;
    bc_nxt    = bc_r;
    hc_nxt    = hc_r;
    sr_nxt    = sr_r;
    lines_nxt = lines_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done      = 1'b0;

    if (cmd_r == CMD_IDLE && in_word.cmd_valid && in_word.req_type <= CMD_SENDACK) begin
      cmd_nxt = in_word.req_type;
      ph_nxt  = 3'd0;
      bc_nxt  = 4'd0;
      hc_nxt  = 8'd0;
      if (in_word.req_type == CMD_WRITE) begin
        sr_nxt = in_word.tx_byte;
      end else if (in_word.req_type == CMD_SENDACK) begin
        sr_nxt = {7'd0, in_word.ack_value};
      end else if (in_word.req_type == CMD_READ) begin
        sr_nxt = 8'd0;
      end
      lines_nxt = enter_phase(cmd_nxt, ph_nxt, sr_nxt, lines_nxt);
    end

    drive = lines_nxt;

    if (cmd_nxt != CMD_IDLE) begin
      hc_nxt = hc_nxt + 8'd1;
      if (hc_nxt >= ticks) begin
        hc_nxt = 8'd0;
        unique case (cmd_nxt)
          CMD_START, CMD_STOP: begin
            if (ph_nxt == 3'd0) begin
              ph_nxt = 3'd1;
            end else begin
              if (cmd_nxt == CMD_START) begin
                lines_nxt.scl = 1'b0;
              end
              done = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (ph_nxt < 3'd2) begin
              ph_nxt = ph_nxt + 3'd1;
            end else begin
              sr_nxt = {sr_nxt[6:0], 1'b0};
              bc_nxt = bc_nxt + 4'd1;
              if (bc_nxt >= 4'(BYTE_BITS)) begin
                lines_nxt.scl = 1'b0;
                done = 1'b1;
              end else begin
                ph_nxt = 3'd0;
              end
            end
          end
          CMD_READ: begin
            if (ph_nxt == 3'd0) begin
              sr_nxt = {sr_nxt[6:0], in_word.sda_in};
              ph_nxt = 3'd1;
            end else begin
              bc_nxt = bc_nxt + 4'd1;
              if (bc_nxt >= 4'(BYTE_BITS)) begin
                rx_nxt = sr_nxt;
                done = 1'b1;
              end else begin
                ph_nxt = 3'd0;
              end
            end
          end
          CMD_WAITACK: begin
            if (ph_nxt == 3'd0) begin
              ack_nxt = in_word.sda_in;
              ph_nxt = 3'd1;
            end else begin
              done = 1'b1;
            end
          end
          CMD_SENDACK: begin
            if (ph_nxt < 3'd2) begin
              ph_nxt = ph_nxt + 3'd1;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            cmd_nxt = CMD_IDLE;
          end
        endcase
        if (done) begin
          cmd_nxt = CMD_IDLE;
          ph_nxt  = 3'd0;
          bc_nxt  = 4'd0;
        end else if (cmd_nxt != CMD_IDLE) begin
          lines_nxt = enter_phase(cmd_nxt, ph_nxt, sr_nxt, lines_nxt);
        end else begin
          ph_nxt = 3'd0;
          bc_nxt = 4'd0;
        end
      end
    end

    out_word.scl_out  = drive.scl;
    out_word.sda_out  = drive.sda;
    out_word.busy_res = (cmd_nxt != CMD_IDLE);
    out_word.done_res = done;
    out_word.rx_byte  = rx_nxt;
    out_word.ack_seen = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= CMD_IDLE;
      ph_r      <= 3'd0;
      bc_r      <= 4'd0;
      hc_r      <= 8'd0;
      sr_r      <= 8'd0;
      lines_r   <= '{scl: 1'b1, sda: 1'b1};
      ack_r     <= 1'b1;
      rx_r      <= 8'd0;
    end else if (step_en) begin
      cmd_r     <= cmd_nxt;
      ph_r      <= ph_nxt;
      bc_r      <= bc_nxt;
      hc_r      <= hc_nxt;
      sr_r      <= sr_nxt;
      lines_r   <= lines_nxt;
      ack_r     <= ack_nxt;
      rx_r      <= rx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2c_master_bit_engine_top.sv =====
// I2C master pin sequencer driven by ticks.
// Input channel (in_valid / in_stall / in_word): one word per tick, carrying
// an optional command (start, stop, write byte, read byte, wait ack, send ack)
// and the sampled SDA level. Commands offered while busy are dropped.
// Result channel (out_valid / out_stall / out_word): exactly one word per
// input word, in order, with the SCL and SDA drive, busy, done pulse, last
// received byte and last acknowledge level.
// Configuration (cfg_valid / cfg_ready / cfg_data): phase hold length in
// ticks, zero acts as one; reset value 6. Write only while idle.
// An accepted word passes through the input register, then the sequencer step
// lands in the result register.
// Throughput is one word per cycle while out_stall is low; the sequencer state
// update is combinational, so the next word is taken in the following cycle.
// When out_stall is high the result register holds, the input register fills
// and in_stall then rises until the result is taken.
// Synchronous reset releases both lines, clears the sequencer to idle and
// empties both registers.
`default_nettype none
module i2c_master_bit_engine_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  i2cmbe_pkg::in_word_t   in_word,
  output logic                   out_valid,
  input  wire                    out_stall,
  output i2cmbe_pkg::out_word_t  out_word,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [7:0]              cfg_data
);
  import i2cmbe_pkg::*;

  in_word_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  out_word_t out_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t res;
  logic [7:0] ticks_r;
  logic      adv;
  logic      in_take;

  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_vld_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  i2cmbe_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .in_word     (in_r),
    .phase_ticks (ticks_r),
    .out_word    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ticks_r   <= PHASE_TICKS_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        ticks_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_word;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire
